@@ hw/rtl/wsd_pkg.sv @@
package wsd_pkg;

   // Field widths
   localparam int WEIGHT_W    = 24;
   localparam int ATTEMPT_W   = 8;
   localparam int SPREAD_W    = 16;
   localparam int COUNT_CFG_W = 5;

   // Configuration port
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_AVERAGE_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SPREAD    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTEMPT_LIMIT = 2'd2;

   localparam logic [COUNT_CFG_W-1:0] AVERAGE_COUNT_RESET = 5'd5;
   localparam logic [SPREAD_W-1:0]    MAX_SPREAD_RESET    = 16'd24;
   localparam logic [ATTEMPT_W-1:0]   ATTEMPT_LIMIT_RESET = 8'd30;

   // Parameter defaults
   localparam int DEFAULT_WINDOW_DEPTH = 5;
   localparam int DEFAULT_MAX_AVERAGE  = 16;

   // Min scan seed: 9999 g in 1/16 g units
   localparam logic signed [WEIGHT_W-1:0] MIN_START = 24'sd159984;

   typedef struct packed {
      logic take;       // accumulate the accepted sample
      logic clear;      // start of measurement: clear ring and counters
      logic load;       // load divider from the group sum
      logic div_step;   // one restoring divide step
      logic win_write;  // store average, seed min/max scan
      logic scan_step;  // fold one ring entry into min/max
      logic emit;       // load the result word
   } wsd_cmd_type;

   typedef struct packed {
      logic group_done; // this sample completes the group
      logic div_last;   // final divide step
      logic scan_last;  // final ring entry
      logic stable;     // spread below threshold
      logic give_up;    // attempt limit reached
   } wsd_status_type;

endpackage

@@ hw/rtl/wsd_ctrl.sv @@
module wsd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_start_measure,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  wsd_pkg::wsd_status_type status,
   output wsd_pkg::wsd_cmd_type    cmd
);
   import wsd_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOAD   = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_WRITE  = 3'd3;
   localparam logic [2:0] S_SCAN   = 3'd4;
   localparam logic [2:0] S_DECIDE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       measuring_ff, measuring_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_busy;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_busy  = rsp_valid_ff && rsp_stall;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cmd.clear    = accept && req_start_measure;
      cmd.take     = accept && (req_start_measure || measuring_ff);
      case (state_ff)
         S_IDLE: begin
            if (cmd.take && status.group_done) state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.win_write = 1'b1;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (status.stable || status.give_up) begin
               // hold here until the output register frees up
               if (!out_busy) begin
                  cmd.emit = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      measuring_in = measuring_ff;
      if (cmd.clear) measuring_in = 1'b1;
      if (cmd.emit) measuring_in = 1'b0;
      rsp_valid_in = cmd.emit || out_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         measuring_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         measuring_ff <= measuring_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_emit_ends_measurement: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (state_ff == S_IDLE) && !measuring_ff)
      else $error("result issued without ending the measurement");

   a_div_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) && ($past(state_ff) != S_DIV) |-> ($past(state_ff) == S_LOAD))
      else $error("divider entered without a load");

endmodule

@@ hw/rtl/wsd_datapath.sv @@
module wsd_datapath #(
   parameter int WINDOW_DEPTH = wsd_pkg::DEFAULT_WINDOW_DEPTH,
   parameter int MAX_AVERAGE  = wsd_pkg::DEFAULT_MAX_AVERAGE
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  wsd_pkg::wsd_cmd_type                 cmd,
   output wsd_pkg::wsd_status_type              status,
   input  logic signed [wsd_pkg::WEIGHT_W-1:0]  req_weight_sample,
   input  logic [$clog2(MAX_AVERAGE+1)-1:0]     count_eff,
   input  logic [wsd_pkg::SPREAD_W-1:0]         max_spread,
   input  logic [wsd_pkg::ATTEMPT_W-1:0]        limit_eff,
   output logic signed [wsd_pkg::WEIGHT_W-1:0]  rsp_result_weight,
   output logic                                 rsp_settled,
   output logic [wsd_pkg::ATTEMPT_W-1:0]        rsp_attempts_used
);
   import wsd_pkg::*;

   localparam int CNT_W  = $clog2(MAX_AVERAGE + 1);
   localparam int SUM_W  = WEIGHT_W + $clog2(MAX_AVERAGE);
   localparam int DCNT_W = $clog2(SUM_W);
   localparam int IDX_W  = $clog2(WINDOW_DEPTH);
   localparam int CMP_W  = SUM_W + 2;
   localparam int MID_W  = SUM_W + 1;

   // group accumulation
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]           taken_ff, taken_in, taken_next;
   logic signed [SUM_W-1:0]    sample_ext;

   // serial divider: quotient shifts in where the dividend shifts out
   logic [SUM_W-1:0]           quot_ff, quot_in;
   logic [CNT_W-1:0]           rem_ff, rem_in;
   logic                       neg_ff;
   logic [DCNT_W-1:0]          dcnt_ff, dcnt_in;
   logic [CNT_W:0]             rem_shift;
   logic                       rem_ge;
   logic [SUM_W-1:0]           sum_mag;
   logic [SUM_W-1:0]           quot_signed;
   logic signed [SUM_W-1:0]    avg;

   // ring and scan; entries keep the full sum width since a count lowered
   // mid-group can leave an average outside the 24-bit word range
   logic signed [SUM_W-1:0]    window_ff [WINDOW_DEPTH];
   logic [IDX_W-1:0]           slot_ff;
   logic [IDX_W-1:0]           scan_idx_ff;
   logic [ATTEMPT_W-1:0]       attempt_ff;
   logic signed [SUM_W-1:0]    lo_ff, hi_ff, entry;

   logic signed [CMP_W-1:0]    spread, thresh;
   logic signed [MID_W-1:0]    mid_sum;

   assign sample_ext = SUM_W'(req_weight_sample);
   assign taken_next = cmd.clear ? CNT_W'(1) : taken_ff + CNT_W'(1);

   always_comb begin
      sum_in   = sum_ff;
      taken_in = taken_ff;
      if (cmd.take) begin
         sum_in   = (cmd.clear ? '0 : sum_ff) + sample_ext;
         taken_in = taken_next;
      end
      if (cmd.load) begin
         sum_in   = '0;
         taken_in = '0;
      end
   end

   assign sum_mag   = sum_ff[SUM_W-1] ? unsigned'(-sum_ff) : unsigned'(sum_ff);
   assign rem_shift = {rem_ff, quot_ff[SUM_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, count_eff});

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dcnt_in = dcnt_ff;
      if (cmd.load) begin
         quot_in = sum_mag;
         rem_in  = '0;
         dcnt_in = '0;
      end else if (cmd.div_step) begin
         quot_in = {quot_ff[SUM_W-2:0], rem_ge};
         rem_in  = rem_ge ? CNT_W'(rem_shift - {1'b0, count_eff}) : rem_shift[CNT_W-1:0];
         dcnt_in = dcnt_ff + DCNT_W'(1);
      end
   end

   // truncation toward zero: divide magnitudes, then restore the sign
   assign quot_signed = neg_ff ? (~quot_ff + SUM_W'(1)) : quot_ff;
   assign avg         = signed'(quot_signed);
   assign entry       = window_ff[scan_idx_ff];

   assign spread  = CMP_W'(hi_ff) - CMP_W'(lo_ff);
   assign thresh  = signed'(CMP_W'(max_spread));
   assign mid_sum = MID_W'(lo_ff) + MID_W'(hi_ff);

   assign status.group_done = (taken_next >= count_eff);
   assign status.div_last   = (dcnt_ff == DCNT_W'(SUM_W - 1));
   assign status.scan_last  = (scan_idx_ff == IDX_W'(WINDOW_DEPTH - 1));
   assign status.stable     = (spread < thresh);
   assign status.give_up    = (attempt_ff >= limit_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         taken_ff   <= '0;
         slot_ff    <= '0;
         attempt_ff <= '0;
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         sum_ff   <= sum_in;
         taken_ff <= taken_in;
         if (cmd.clear) begin
            slot_ff    <= '0;
            attempt_ff <= '0;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
               window_ff[i] <= '0;
            end
         end else if (cmd.win_write) begin
            window_ff[slot_ff] <= avg;
            slot_ff    <= (slot_ff == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : slot_ff + IDX_W'(1);
            attempt_ff <= attempt_ff + ATTEMPT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dcnt_ff <= dcnt_in;
      if (cmd.load) neg_ff <= sum_ff[SUM_W-1];
      if (cmd.win_write) begin
         lo_ff       <= SUM_W'(MIN_START);
         hi_ff       <= '0;
         scan_idx_ff <= '0;
      end else if (cmd.scan_step) begin
         if (entry < lo_ff) lo_ff <= entry;
         if (entry > hi_ff) hi_ff <= entry;
         scan_idx_ff <= scan_idx_ff + IDX_W'(1);
      end
      if (cmd.emit) begin
         // midpoint: arithmetic shift rounds toward minus infinity
         rsp_result_weight <= status.stable ? mid_sum[WEIGHT_W:1] : window_ff[0][WEIGHT_W-1:0];
         rsp_settled       <= status.stable;
         rsp_attempts_used <= attempt_ff;
      end
   end

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff < IDX_W'(WINDOW_DEPTH - 1) || slot_ff == IDX_W'(WINDOW_DEPTH - 1))
      else $error("ring write slot past the last entry");

   a_emit_after_average: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> attempt_ff != '0)
      else $error("result issued before any average was made");

endmodule

@@ hw/rtl/weight_stability_detector.sv @@
// Weight stability detector. Signed load-cell words (1/16 g) come in on req_; a word with
// req_start_measure set clears the ring and counters, starts a measurement and counts as its
// first sample. Words arriving while no measurement runs are dropped. Every average_count
// samples are summed and divided by the count (quotient truncated toward zero); the average
// goes into a WINDOW_DEPTH-entry ring and the ring is scanned for min (seeded at 9999 g) and
// max (seeded at 0). If max - min < max_spread, the midpoint (min + max) >>> 1 is returned
// with settled = 1; otherwise, once attempt_limit averages have been made, ring entry 0 is
// returned with settled = 0. Either result ends the measurement. Timing: a word that does
// not complete a group does not stall the next one. A word that completes a group holds off
// the next word while the restoring divider runs, one bit per cycle over SUM_W = 24 +
// clog2(MAX_AVERAGE) bits, and the ring is scanned, one entry per cycle; req_stall is high
// for all of that but the accepting cycle, and longer while an earlier result still waits.
// The result word sits in an output register, so input words keep being taken while it
// waits; a second result waits for the first to leave. The user must write the registers
// over csr_ only while the block is idle; the block itself does not enforce this. They are
// average_count (index 0, 0 acts as 1, values above MAX_AVERAGE saturate), max_spread
// (index 1) and attempt_limit (index 2, 0 acts as 1).
module weight_stability_detector #(
   parameter int WINDOW_DEPTH = wsd_pkg::DEFAULT_WINDOW_DEPTH,
   parameter int MAX_AVERAGE  = wsd_pkg::DEFAULT_MAX_AVERAGE
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [wsd_pkg::WEIGHT_W-1:0]  req_weight_sample,
   input  logic                                 req_start_measure,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [wsd_pkg::WEIGHT_W-1:0]  rsp_result_weight,
   output logic                                 rsp_settled,
   output logic [wsd_pkg::ATTEMPT_W-1:0]        rsp_attempts_used,
   // register write port
   input  logic                                 csr_write_enable,
   input  logic [wsd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [wsd_pkg::CSR_DATA_W-1:0]       csr_write_data
);
   import wsd_pkg::*;

   localparam int CNT_W = $clog2(MAX_AVERAGE + 1);

   logic [COUNT_CFG_W-1:0] average_count_ff;
   logic [SPREAD_W-1:0]    max_spread_ff;
   logic [ATTEMPT_W-1:0]   attempt_limit_ff;

   logic [31:0]            count_wide;
   logic [CNT_W-1:0]       count_eff;
   logic [ATTEMPT_W-1:0]   limit_eff;

   wsd_cmd_type            cmd;
   wsd_status_type         status;

   // register file; writes to unused indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         average_count_ff <= AVERAGE_COUNT_RESET;
         max_spread_ff    <= MAX_SPREAD_RESET;
         attempt_limit_ff <= ATTEMPT_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_AVERAGE_COUNT: average_count_ff <= csr_write_data[COUNT_CFG_W-1:0];
            CSR_MAX_SPREAD:    max_spread_ff    <= csr_write_data[SPREAD_W-1:0];
            CSR_ATTEMPT_LIMIT: attempt_limit_ff <= csr_write_data[ATTEMPT_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp the group size to 1..MAX_AVERAGE, the limit to at least 1
   assign count_wide = 32'(average_count_ff);

   always_comb begin
      if (count_wide == 32'd0) begin
         count_eff = CNT_W'(1);
      end else if (count_wide > 32'(MAX_AVERAGE)) begin
         count_eff = CNT_W'(MAX_AVERAGE);
      end else begin
         count_eff = count_wide[CNT_W-1:0];
      end
   end

   assign limit_eff = (attempt_limit_ff == '0) ? ATTEMPT_W'(1) : attempt_limit_ff;

   wsd_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_start_measure (req_start_measure),
      .req_stall         (req_stall),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .status            (status),
      .cmd               (cmd)
   );

   wsd_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .MAX_AVERAGE  (MAX_AVERAGE)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_weight_sample (req_weight_sample),
      .count_eff         (count_eff),
      .max_spread        (max_spread_ff),
      .limit_eff         (limit_eff),
      .rsp_result_weight (rsp_result_weight),
      .rsp_settled       (rsp_settled),
      .rsp_attempts_used (rsp_attempts_used)
   );

endmodule

@@ tb/tb_top.sv @@
module tb_top;
   import wsd_pkg::*;

   localparam int RING_DEPTH      = DEFAULT_WINDOW_DEPTH;
   localparam int COUNT_CAP       = DEFAULT_MAX_AVERAGE;
   // A group-completing word keeps the block busy while it divides and scans the ring;
   // wait well past that before touching the registers.
   localparam int SETTLE_CYCLES   = 100;
   localparam int HOLD_OFF_CYCLES = 1500;
   localparam int TIMEOUT_CYCLES  = 400000;
   localparam int RANDOM_WORDS    = 600;
   localparam int MAX_REPORTS     = 100;

   // One result word as it leaves the block
   typedef struct packed {
      logic signed [WEIGHT_W-1:0] weight;
      logic                       settled;
      logic [ATTEMPT_W-1:0]       attempts;
   } reading_type;

   // One sample word as it enters the block
   typedef struct packed {
      logic signed [WEIGHT_W-1:0] weight;
      logic                       start;
   } load_word_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic signed [WEIGHT_W-1:0]  req_weight_sample;
   logic                        req_start_measure;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic signed [WEIGHT_W-1:0]  rsp_result_weight;
   logic                        rsp_settled;
   logic [ATTEMPT_W-1:0]        rsp_attempts_used;
   logic                        csr_write_enable;
   logic [CSR_INDEX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]       csr_write_data;

   weight_stability_detector i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_weight_sample (req_weight_sample),
      .req_start_measure (req_start_measure),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_weight (rsp_result_weight),
      .rsp_settled       (rsp_settled),
      .rsp_attempts_used (rsp_attempts_used),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   // Stimulus and scoreboard storage
   load_word_type pending_words[$];
   reading_type   expected_readings[$];

   // Predictor copy of the registers and the measurement state
   logic [COUNT_CFG_W-1:0] cfg_average_count;
   logic [SPREAD_W-1:0]    cfg_max_spread;
   logic [ATTEMPT_W-1:0]   cfg_attempt_limit;
   int                     ring[RING_DEPTH];
   int                     ring_slot;
   int                     group_sum;
   int                     group_fill;
   int                     averages_made;
   bit                     measuring;

   // Handshake bookkeeping between the sampling edge and the driving edge
   bit word_taken;
   bit offering;
   int gap_left;
   int burst_left;
   int sender_mode;
   int receiver_mode;
   int stall_left;
   int hold_left;
   bit hold_armed;

   // Run statistics
   int error_count;
   int words_taken;
   int random_words;
   int readings_seen;
   int settled_seen;
   int csr_writes;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_CYCLES * 12);
      $display("Timeout after %0d cycles, %0d readings still owed",
               TIMEOUT_CYCLES, expected_readings.size());
      $display("Simulation FAILED");
      $finish;
   end

   task automatic flag_error(input string msg);
      if (error_count < MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic void clear_measurement();
      ring          = '{default: 0};
      ring_slot     = 0;
      group_sum     = 0;
      group_fill    = 0;
      averages_made = 0;
   endfunction

   // Predictor: fold one accepted sample word into the measurement and queue the
   // reading it produces, if any.
   function automatic void weigh_word(input logic signed [WEIGHT_W-1:0] wt,
                                      input logic start);
      int          eff_count;
      int          eff_limit;
      int          avg;
      int          lo;
      int          hi;
      reading_type r;
      if (start) begin
         clear_measurement();
         measuring = 1'b1;
      end
      if (!measuring) return;   // between measurements words are dropped
      eff_count = (cfg_average_count == 0) ? 1 :
                  ((cfg_average_count > COUNT_CAP) ? COUNT_CAP : int'(cfg_average_count));
      eff_limit = (cfg_attempt_limit == 0) ? 1 : int'(cfg_attempt_limit);
      group_sum += wt;
      group_fill++;
      // >= so that a count lowered mid-group closes the group on the next word
      if (group_fill < eff_count) return;
      avg = group_sum / eff_count;   // truncates toward zero
      group_sum  = 0;
      group_fill = 0;
      ring[ring_slot] = avg;
      ring_slot = (ring_slot + 1) % RING_DEPTH;
      averages_made = (averages_made + 1) & 8'hFF;
      // scan seeds: min at 9999 g, max at 0
      lo = int'(MIN_START);
      hi = 0;
      foreach (ring[i]) begin
         if (ring[i] < lo) lo = ring[i];
         if (ring[i] > hi) hi = ring[i];
      end
      if (hi - lo < int'(cfg_max_spread)) begin
         r.weight   = WEIGHT_W'((lo + hi) >>> 1);   // floor of the midpoint
         r.settled  = 1'b1;
         r.attempts = ATTEMPT_W'(averages_made);
         expected_readings.push_back(r);
         measuring = 1'b0;
      end else if (averages_made >= eff_limit) begin
         r.weight   = WEIGHT_W'(ring[0]);
         r.settled  = 1'b0;
         r.attempts = ATTEMPT_W'(averages_made);
         expected_readings.push_back(r);
         measuring = 1'b0;
      end
   endfunction

   // Queue a sample word, clipped to the 24-bit range
   function automatic void offer_word(input longint wt, input bit start);
      load_word_type w;
      if (wt > 64'sd8388607) wt = 64'sd8388607;
      if (wt < -64'sd8388608) wt = -64'sd8388608;
      w.weight = wt[WEIGHT_W-1:0];
      w.start  = start;
      pending_words.push_back(w);
   endfunction

   function automatic longint any_weight();
      return longint'($urandom_range(0, 24'hFFFFFF)) - 64'sd8388608;
   endfunction

   // One measurement: mostly a steady weight with noise, so that the ring fills and
   // settles or runs out of attempts; some fully random, cut short, idle noise with no start, or with stray starts.
   function automatic void random_measurement(input int eff_count, input int eff_limit,
                                              input int spread);
      int     kind;
      int     n_words;
      int     amp;
      longint center;
      longint noise;
      kind    = $urandom_range(0, 9);
      n_words = eff_count * $urandom_range(1, (eff_limit + 1 > 8) ? 8 : eff_limit + 1);
      amp     = $urandom_range(0, spread / 3 + 1);
      case ($urandom_range(0, 4))
         0: center = longint'($urandom_range(0, spread + 1)) - spread / 2;
         1: center = $urandom_range(0, 160000);
         2: center = 159984 + longint'($urandom_range(0, 2 * amp + 2)) - amp - 1;
         3: center = -longint'($urandom_range(0, 2000000));
         default: center = $urandom_range(0, 8388607);
      endcase
      if (kind == 7) n_words = $urandom_range(1, n_words);   // abandoned early
      for (int i = 0; i < n_words; i++) begin
         noise = longint'($urandom_range(0, 2 * amp)) - amp;
         if (kind < 6 || kind == 7) offer_word(center + noise, i == 0);
         else if (kind < 7) offer_word(any_weight(), i == 0);
         else if (kind == 8) offer_word(any_weight(), 1'b0);   // idle noise
         else offer_word(center + noise, i == 0 || $urandom_range(0, 15) == 0);
      end
      if (kind != 8) random_words += n_words;
   endfunction

   // Register writes, one per cycle, only while the block is idle
   task automatic write_config(input logic [COUNT_CFG_W-1:0] count,
                               input logic [SPREAD_W-1:0] spread,
                               input logic [ATTEMPT_W-1:0] limit);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_AVERAGE_COUNT;
      csr_write_data   <= CSR_DATA_W'(count);
      @(negedge clock);
      csr_index        <= CSR_MAX_SPREAD;
      csr_write_data   <= CSR_DATA_W'(spread);
      @(negedge clock);
      csr_index        <= CSR_ATTEMPT_LIMIT;
      csr_write_data   <= CSR_DATA_W'(limit);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Wait until every word is in and every reading is out, then let a group that
   // produced no reading finish inside the block.
   task automatic drain();
      while (pending_words.size() > 0 || offering || expected_readings.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Sample side: offers words in bursts with random gaps; a stalled word is held.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (word_taken) begin
            void'(pending_words.pop_front());
            word_taken = 1'b0;
            offering   = 1'b0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_words.size() > 0) begin
               offering = 1'b1;
               req_weight_sample <= pending_words[0].weight;
               req_start_measure <= pending_words[0].start;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left   = (sender_mode == 0) ? 0 :
                               (sender_mode == 1) ? $urandom_range(0, 3) :
                                                    $urandom_range(0, 25);
               end
            end
         end
         req_valid <= offering;
      end
   end

   // Result side: stall pattern per phase, plus one long hold-off when armed
   always @(negedge clock) begin
      if (hold_armed) begin
         hold_armed = 1'b0;
         hold_left  = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (receiver_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            default: begin
               if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 30);
               rsp_stall <= 1'b0;
            end
         endcase
      end
   end

   // Sampling edge: check readings, run the predictor on taken words, track writes
   always @(posedge clock) begin : monitor
      reading_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            readings_seen++;
            if (rsp_settled === 1'b1) settled_seen++;
            if (expected_readings.size() == 0) begin
               flag_error($sformatf("unexpected reading weight=%0d settled=%0b attempts=%0d",
                                    rsp_result_weight, rsp_settled, rsp_attempts_used));
            end else begin
               want = expected_readings.pop_front();
               if (rsp_result_weight !== want.weight)
                  flag_error($sformatf("reading %0d: weight %0d, want %0d", readings_seen,
                                       rsp_result_weight, want.weight));
               if (rsp_settled !== want.settled)
                  flag_error($sformatf("reading %0d: settled %0b, want %0b", readings_seen,
                                       rsp_settled, want.settled));
               if (rsp_attempts_used !== want.attempts)
                  flag_error($sformatf("reading %0d: attempts %0d, want %0d", readings_seen,
                                       rsp_attempts_used, want.attempts));
            end
         end
         if (req_valid && !req_stall) begin
            weigh_word(req_weight_sample, req_start_measure);
            word_taken = 1'b1;
            words_taken++;
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_AVERAGE_COUNT: cfg_average_count = csr_write_data[COUNT_CFG_W-1:0];
               CSR_MAX_SPREAD:    cfg_max_spread    = csr_write_data[SPREAD_W-1:0];
               CSR_ATTEMPT_LIMIT: cfg_attempt_limit = csr_write_data[ATTEMPT_W-1:0];
               default: ;
            endcase
            csr_writes++;
         end
      end
   end

   initial begin : stimulus
      int                     phase;
      int                     pick;
      int                     eff_count;
      int                     eff_limit;
      bit                     pressure;
      logic [COUNT_CFG_W-1:0] new_count;
      logic [SPREAD_W-1:0]    new_spread;
      logic [ATTEMPT_W-1:0]   new_limit;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_weight_sample = '0;
      req_start_measure = 1'b0;
      rsp_stall         = 1'b0;
      csr_write_enable  = 1'b0;
      csr_index         = CSR_AVERAGE_COUNT;
      csr_write_data    = '0;
      cfg_average_count = AVERAGE_COUNT_RESET;
      cfg_max_spread    = MAX_SPREAD_RESET;
      cfg_attempt_limit = ATTEMPT_LIMIT_RESET;
      measuring         = 1'b0;
      clear_measurement();
      sender_mode       = 0;
      receiver_mode     = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Register values out of reset (5 / 24 / 30): a word before any start is
      // dropped, then five zero words settle on the first average.
      offer_word(123, 1'b0);
      offer_word(0, 1'b1);
      repeat (4) offer_word(0, 1'b0);
      drain();

      // Zero count acts as one, limit one: every start gives up on its own word.
      // Field extremes and the min seed value itself.
      write_config(5'd0, 16'd0, 8'd1);
      offer_word(8388607, 1'b1);
      offer_word(-8388608, 1'b1);
      offer_word(159984, 1'b1);
      offer_word(0, 1'b1);    // spread 0 is never below a zero threshold
      drain();

      // Pairs, zero limit acts as one, widest threshold. Truncation of a negative
      // quotient, floor of a negative midpoint, spread just at the threshold,
      // and a start that abandons a running measurement.
      write_config(5'd2, 16'hFFFF, 8'd0);
      offer_word(7, 1'b1);
      offer_word(-8, 1'b0);
      offer_word(-7, 1'b1);
      offer_word(0, 1'b0);
      offer_word(65535, 1'b1);
      offer_word(65535, 1'b0);
      offer_word(100, 1'b1);
      offer_word(100, 1'b1);
      offer_word(100, 1'b0);
      drain();

      // Count above the cap: three words leave a group open...
      write_config(5'd31, 16'hFFFF, 8'hFF);
      offer_word(30, 1'b1);
      repeat (2) offer_word(30, 1'b0);
      drain();
      // ...and lowering the count closes it on the next word.
      write_config(5'd2, 16'd200, 8'd3);
      offer_word(30, 1'b0);
      drain();

      // Random phases with a fresh register set each time; the first one is the
      // long result-side hold-off so that it always runs
      phase = 0;
      while (random_words < RANDOM_WORDS) begin
         pressure      = (phase == 0);
         sender_mode   = pressure ? 0 : $urandom_range(0, 2);
         receiver_mode = $urandom_range(0, 2);
         pick = $urandom_range(0, 9);
         new_count  = (pick == 0) ? 5'd0 : (pick == 1) ? 5'd31 : (pick == 2) ? 5'd16 :
                      (pick == 3) ? 5'($urandom_range(17, 30)) : 5'($urandom_range(1, 5));
         pick = $urandom_range(0, 9);
         new_spread = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                      (pick == 2) ? 16'($urandom_range(0, 65535)) :
                                    16'($urandom_range(4, 400));
         pick = $urandom_range(0, 9);
         new_limit  = (pick == 0) ? 8'd0 : (pick == 1) ? 8'hFF :
                      (pick == 2) ? 8'($urandom_range(11, 60)) : 8'($urandom_range(1, 10));
         if (pressure) begin
            // one reading per start word while the result side holds off
            new_count = 5'd1;
            new_limit = 8'd1;
         end
         write_config(new_count, new_spread, new_limit);
         eff_count = (new_count == 0) ? 1 :
                     ((new_count > COUNT_CAP) ? COUNT_CAP : int'(new_count));
         eff_limit = (new_limit == 0) ? 1 : int'(new_limit);
         if (pressure) begin
            hold_armed = 1'b1;
            repeat (40) offer_word(any_weight(), 1'b1);
            random_words += 40;
         end else begin
            repeat (6) random_measurement(eff_count, eff_limit, int'(new_spread));
         end
         drain();
         phase++;
      end

      $display("Run covered %0d taken sample words over %0d random phases, %0d register writes",
               words_taken, phase, csr_writes);
      $display("Readings checked: %0d (%0d settled, %0d gave up), mismatches: %0d",
               readings_seen, settled_seen, readings_seen - settled_seen, error_count);
      if (error_count == 0 && expected_readings.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
